>>> src/y4m_luma_extractor_unit_defines.svh
// Assertion macros used by the luma extractor parser.
`ifndef Y4M_LUMA_EXTRACTOR_UNIT_DEFINES_SVH
`define Y4M_LUMA_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define Y4MLE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define Y4MLE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/y4mle_pkg.sv
// Types, codes and character helpers for the luma extractor.
package y4mle_pkg;

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_MAGIC_SEP,
		PH_HEADER,
		PH_TOKEN,
		PH_TOKEN_SEP,
		PH_LUMA,
		PH_CHROMA,
		PH_HALT
	} phase_t;

	typedef enum logic [1:0] {
		TAG_NONE,
		TAG_W,
		TAG_H,
		TAG_SKIP
	} tag_t;

	localparam logic [1:0] ST_PIXEL     = 2'd0;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
	localparam logic [1:0] ST_END       = 2'd2;

	localparam logic [3:0] MAGIC_LEN = 4'd9;
	localparam logic [3:0] FRAME_LEN = 4'd5;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_W       = 8'h57;
	localparam logic [7:0] CH_H       = 8'h48;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	typedef struct packed {
		logic        emit;
		logic [7:0]  pixel;
		logic [11:0] row;
		logic [11:0] column;
		logic        last;
		logic [1:0]  status;
	} result_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic [7:0] magic_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h59;
			4'd1:    c = 8'h55;
			4'd2:    c = 8'h56;
			4'd3:    c = 8'h34;
			4'd4:    c = 8'h4D;
			4'd5:    c = 8'h50;
			4'd6:    c = 8'h45;
			4'd7:    c = 8'h47;
			4'd8:    c = 8'h32;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] frame_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h46;
			3'd1:    c = 8'h52;
			3'd2:    c = 8'h41;
			3'd3:    c = 8'h4D;
			3'd4:    c = 8'h45;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> src/y4mle_parser.sv
// Stream parser: header decode, frame tracking and per-byte result.
`include "y4m_luma_extractor_unit_defines.svh"

module y4mle_parser
	import y4mle_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_in,
	input  logic       restart,
	output result_t    res
);

	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int PW   = WW + HW;
	localparam int CRAW = $clog2((MAX_WIDTH * MAX_HEIGHT) / 2 + 1);
	localparam int CW   = (CRAW < 1) ? 1 : CRAW;

	localparam logic [WW+3:0] W_LIMIT = (WW + 4)'(MAX_WIDTH);
	localparam logic [HW+3:0] H_LIMIT = (HW + 4)'(MAX_HEIGHT);

	phase_t          phase_q, phase_d, r_phase;
	logic [3:0]      match_q, match_d, r_match;
	tag_t            tag_q, tag_d, r_tag;
	logic [WW-1:0]   width_q, width_d, r_width;
	logic [HW-1:0]   height_q, height_d, r_height;
	logic [HW-1:0]   row_q, row_d, r_row;
	logic [WW-1:0]   col_q, col_d, r_col;
	logic [CW-1:0]   chroma_q, chroma_d, r_chroma;
	logic [PW-1:0]   area_q;
	logic [PW-1:0]   area_half;

	logic            sp;
	logic            digit;
	logic [3:0]      digit_val;
	logic            magic_hit;
	logic            frame_hit;
	logic            col_end;
	logic            row_end;
	logic [WW+3:0]   width_acc;
	logic [HW+3:0]   height_acc;
	logic [HW+11:0]  row_ext;
	logic [WW+11:0]  col_ext;

	always_comb begin
		r_phase  = restart ? PH_MAGIC : phase_q;
		r_match  = restart ? 4'd0 : match_q;
		r_tag    = restart ? TAG_NONE : tag_q;
		r_width  = restart ? '0 : width_q;
		r_height = restart ? '0 : height_q;
		r_row    = restart ? '0 : row_q;
		r_col    = restart ? '0 : col_q;
		r_chroma = restart ? '0 : chroma_q;
	end

	assign sp        = is_space(byte_in);
	assign digit     = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
	assign digit_val = 4'(byte_in - CH_ZERO);
	assign magic_hit = (r_match < MAGIC_LEN) && (byte_in == magic_char(r_match));
	assign frame_hit = (r_match < FRAME_LEN) && (byte_in == frame_char(r_match[2:0]));
	assign col_end   = ({1'b0, r_col} + 1'b1) >= {1'b0, r_width};
	assign row_end   = ({1'b0, r_row} + 1'b1) >= {1'b0, r_height};
	assign width_acc = {4'd0, r_width} * (WW + 4)'(10) + (WW + 4)'(digit_val);
	assign height_acc = {4'd0, r_height} * (HW + 4)'(10) + (HW + 4)'(digit_val);
	assign area_half = area_q >> 1;
	assign row_ext   = (HW + 12)'(r_row);
	assign col_ext   = (WW + 12)'(r_col);

	always_comb begin
		logic hdr;
		hdr      = 1'b0;
		phase_d  = r_phase;
		match_d  = r_match;
		tag_d    = r_tag;
		width_d  = r_width;
		height_d = r_height;
		row_d    = r_row;
		col_d    = r_col;
		chroma_d = r_chroma;
		unique case (r_phase)
			PH_MAGIC: begin
				if (!((r_match == 4'd0) && sp)) begin
					if (magic_hit) begin
						match_d = r_match + 4'd1;
						if (r_match == MAGIC_LEN - 4'd1) begin
							phase_d = PH_MAGIC_SEP;
						end
					end else begin
						phase_d = PH_HALT;
					end
				end
			end
			PH_MAGIC_SEP: begin
				if (!sp) begin
					phase_d = PH_HALT;
				end else begin
					phase_d = PH_HEADER;
					tag_d   = TAG_NONE;
				end
			end
			PH_HEADER: begin
				hdr = 1'b1;
				if ((r_tag == TAG_W) || (r_tag == TAG_H)) begin
					if (digit) begin
						hdr = 1'b0;
						if (r_tag == TAG_W) begin
							width_d = (width_acc > W_LIMIT) ? W_LIMIT[WW-1:0] : width_acc[WW-1:0];
						end else begin
							height_d = (height_acc > H_LIMIT) ? H_LIMIT[HW-1:0]
								: height_acc[HW-1:0];
						end
					end else begin
						tag_d = TAG_NONE;
					end
				end else if (r_tag == TAG_SKIP) begin
					if (!sp) begin
						hdr = 1'b0;
					end else begin
						tag_d = TAG_NONE;
					end
				end
				if (hdr) begin
					if (byte_in == CH_NEWLINE) begin
						phase_d = PH_TOKEN;
						match_d = 4'd0;
						tag_d   = TAG_NONE;
					end else if (byte_in == CH_W) begin
						tag_d   = TAG_W;
						width_d = '0;
					end else if (byte_in == CH_H) begin
						tag_d    = TAG_H;
						height_d = '0;
					end else if (!sp) begin
						tag_d = TAG_SKIP;
					end
				end
			end
			PH_TOKEN: begin
				if (!((r_match == 4'd0) && sp)) begin
					if (frame_hit) begin
						match_d = r_match + 4'd1;
						if (r_match == FRAME_LEN - 4'd1) begin
							phase_d = PH_TOKEN_SEP;
						end
					end else begin
						phase_d = PH_HALT;
					end
				end
			end
			PH_TOKEN_SEP: begin
				if (!sp) begin
					phase_d = PH_HALT;
				end else begin
					row_d   = '0;
					col_d   = '0;
					match_d = 4'd0;
					phase_d = ((r_width == '0) || (r_height == '0)) ? PH_TOKEN : PH_LUMA;
				end
			end
			PH_LUMA: begin
				if (row_end && col_end) begin
					chroma_d = area_half[CW-1:0];
					row_d    = '0;
					col_d    = '0;
					match_d  = 4'd0;
					phase_d  = (area_half == '0) ? PH_TOKEN : PH_CHROMA;
				end else if (col_end) begin
					col_d = '0;
					row_d = r_row + 1'b1;
				end else begin
					col_d = r_col + 1'b1;
				end
			end
			PH_CHROMA: begin
				if (r_chroma != '0) begin
					chroma_d = r_chroma - 1'b1;
				end
				if ((r_chroma == CW'(1)) || (r_chroma == '0)) begin
					match_d = 4'd0;
					phase_d = PH_TOKEN;
				end
			end
			PH_HALT: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res = '0;
		unique case (r_phase)
			PH_MAGIC: begin
				if (!((r_match == 4'd0) && sp) && !magic_hit) begin
					res.emit   = 1'b1;
					res.status = ST_BAD_MAGIC;
				end
			end
			PH_MAGIC_SEP: begin
				if (!sp) begin
					res.emit   = 1'b1;
					res.status = ST_BAD_MAGIC;
				end
			end
			PH_TOKEN: begin
				if (!((r_match == 4'd0) && sp) && !frame_hit) begin
					res.emit   = 1'b1;
					res.status = ST_END;
				end
			end
			PH_TOKEN_SEP: begin
				if (!sp) begin
					res.emit   = 1'b1;
					res.status = ST_END;
				end
			end
			PH_LUMA: begin
				res.emit   = 1'b1;
				res.pixel  = byte_in;
				res.row    = row_ext[11:0];
				res.column = col_ext[11:0];
				res.last   = row_end && col_end;
				res.status = ST_PIXEL;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAGIC;
			match_q  <= 4'd0;
			tag_q    <= TAG_NONE;
			width_q  <= '0;
			height_q <= '0;
			row_q    <= '0;
			col_q    <= '0;
			chroma_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			match_q  <= match_d;
			tag_q    <= tag_d;
			width_q  <= width_d;
			height_q <= height_d;
			row_q    <= row_d;
			col_q    <= col_d;
			chroma_q <= chroma_d;
		end
	end

	// frame area settles long before the first luma byte
	always_ff @(posedge clk) begin
		area_q <= PW'(width_q) * PW'(height_q);
	end

	`Y4MLE_ASSERT_IMP(a_halt_silent, step && !restart && (phase_q == PH_HALT), !res.emit, "halted parser produced an item")
	`Y4MLE_ASSERT_IMP(a_luma_emits, step && !restart && (phase_q == PH_LUMA), res.emit && (res.status == ST_PIXEL), "luma byte without pixel item")
	`Y4MLE_ASSERT_IMP(a_pos_in_frame, phase_q == PH_LUMA, (col_q < width_q) && (row_q < height_q), "luma position outside frame")
	`Y4MLE_ASSERT_NXT(a_error_halts, step && res.emit && (res.status != ST_PIXEL), phase_q == PH_HALT, "error item did not halt parser")

endmodule

>>> src/y4m_luma_extractor_unit.sv
// Top level of the YUV4MPEG2 luma extractor: stream handshake around the parser.
//
//   channel  | dir | tdata                               | tuser        | tlast
//   s_axis   | in  | [7:0] byte_req                      | [0] restart  | -
//   m_axis   | out | [7:0] pixel [19:8] row [31:20] col  | [1:0] status | frame_last
//
// One byte per clock sustained while the output is not stalled; a byte waits in the input
// register, and its item is registered into the output register as the byte leaves it.
// The parser state advances once per byte, in the cycle the byte leaves the input register.
// arst_n clears the parser to wait for the magic word; restart does the same per byte.
// A stalled output holds its item and the input register, backing up s_axis_tready.
module y4m_luma_extractor_unit
	import y4mle_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_req
	input  logic        s_axis_tuser,   // [0] restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] pixel, [19:8] row, [31:20] column
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	output logic        m_axis_tlast    // frame_last
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        restart_s1;
	logic        valid_s2;
	logic [31:0] data_s2;
	logic [1:0]  status_s2;
	logic        last_s2;
	logic        advance;
	logic        step;
	result_t     res;

	assign advance       = !valid_s2 || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	y4mle_parser #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.byte_in(byte_s1),
		.restart(restart_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= step && res.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1    <= s_axis_tdata;
			restart_s1 <= s_axis_tuser;
		end
		if (step) begin
			data_s2   <= {res.column, res.row, res.pixel};
			status_s2 <= res.status;
			last_s2   <= res.last;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;
	assign m_axis_tuser  = status_s2;
	assign m_axis_tlast  = last_s2;

endmodule

>>> sim/y4m_luma_extractor_checker.sv
`timescale 1ns / 1ps
// Luma extractor checker: predicts results from accepted bytes and compares them as they leave.
module y4m_luma_extractor_checker
	import y4mle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_req
	input  logic        s_axis_tuser,   // [0] restart
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // [7:0] pixel, [19:8] row, [31:20] column
	input  logic [1:0]  m_axis_tuser,   // [1:0] status
	input  logic        m_axis_tlast,   // frame_last
	output int          mismatches,
	output int          outstanding
);

	localparam int unsigned DIM_W_MAX = 4096;
	localparam int unsigned DIM_H_MAX = 4096;
	localparam logic [71:0] MAGIC_TXT = "YUV4MPEG2";
	localparam logic [39:0] FRAME_TXT = "FRAME";

	typedef struct packed {
		logic [7:0]  pixel;
		logic [11:0] row;
		logic [11:0] column;
		logic        last;
		logic [1:0]  status;
	} luma_item_t;

	luma_item_t  luma_q[$];
	phase_t      phase;
	tag_t        tag;
	int unsigned match_pos;
	int unsigned width_px;
	int unsigned height_px;
	int unsigned row_at;
	int unsigned col_at;
	int unsigned chroma_left;
	int unsigned result_idx;
	int          miss_count = 0;

	assign mismatches = miss_count;

	function automatic bit ws_byte(input logic [7:0] b);
		return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
	endfunction

	function automatic logic [7:0] magic_at(input int unsigned i);
		return MAGIC_TXT[71 - 8 * i -: 8];
	endfunction

	function automatic logic [7:0] frame_at(input int unsigned i);
		return FRAME_TXT[39 - 8 * i -: 8];
	endfunction

	function automatic int unsigned grow(input int unsigned v, input int unsigned d,
		input int unsigned lim);
		int unsigned n;
		n = v * 10 + d;
		return (n > lim) ? lim : n;
	endfunction

	task automatic clear_parser();
		phase = PH_MAGIC;
		tag = TAG_NONE;
		match_pos = 0;
		width_px = 0;
		height_px = 0;
		row_at = 0;
		col_at = 0;
		chroma_left = 0;
	endtask

	task automatic header_char(input logic [7:0] b);
		if (b == CH_NEWLINE) begin
			phase = PH_TOKEN;
			match_pos = 0;
			tag = TAG_NONE;
		end else if (b == CH_W) begin
			tag = TAG_W;
			width_px = 0;
		end else if (b == CH_H) begin
			tag = TAG_H;
			height_px = 0;
		end else if (!ws_byte(b)) begin
			tag = TAG_SKIP;
		end
	endtask

	task automatic step_parser(input logic [7:0] b, input logic rs, output bit made,
		output luma_item_t res);
		bit fin;
		bit taken;
		made = 1'b0;
		res = '0;
		taken = 1'b0;
		if (rs)
			clear_parser();
		case (phase)
			PH_MAGIC: begin
				if (!(match_pos == 0 && ws_byte(b))) begin
					if (match_pos < MAGIC_LEN && b == magic_at(match_pos)) begin
						match_pos++;
						if (match_pos == MAGIC_LEN)
							phase = PH_MAGIC_SEP;
					end else begin
						phase = PH_HALT;
						made = 1'b1;
						res.status = ST_BAD_MAGIC;
					end
				end
			end
			PH_MAGIC_SEP: begin
				if (!ws_byte(b)) begin
					phase = PH_HALT;
					made = 1'b1;
					res.status = ST_BAD_MAGIC;
				end else begin
					phase = PH_HEADER;
					tag = TAG_NONE;
				end
			end
			PH_HEADER: begin
				if (tag == TAG_W || tag == TAG_H) begin
					if (b >= CH_ZERO && b <= CH_NINE) begin
						if (tag == TAG_W)
							width_px = grow(width_px, b - CH_ZERO, DIM_W_MAX);
						else
							height_px = grow(height_px, b - CH_ZERO, DIM_H_MAX);
						taken = 1'b1;
					end else begin
						tag = TAG_NONE;
					end
				end else if (tag == TAG_SKIP) begin
					if (!ws_byte(b))
						taken = 1'b1;
					else
						tag = TAG_NONE;
				end
				if (!taken)
					header_char(b);
			end
			PH_TOKEN: begin
				if (!(match_pos == 0 && ws_byte(b))) begin
					if (match_pos < FRAME_LEN && b == frame_at(match_pos)) begin
						match_pos++;
						if (match_pos == FRAME_LEN)
							phase = PH_TOKEN_SEP;
					end else begin
						phase = PH_HALT;
						made = 1'b1;
						res.status = ST_END;
					end
				end
			end
			PH_TOKEN_SEP: begin
				if (!ws_byte(b)) begin
					phase = PH_HALT;
					made = 1'b1;
					res.status = ST_END;
				end else begin
					row_at = 0;
					col_at = 0;
					match_pos = 0;
					phase = (width_px == 0 || height_px == 0) ? PH_TOKEN : PH_LUMA;
				end
			end
			PH_LUMA: begin
				fin = (row_at + 1 >= height_px) && (col_at + 1 >= width_px);
				made = 1'b1;
				res.pixel = b;
				res.row = row_at[11:0];
				res.column = col_at[11:0];
				res.last = fin;
				res.status = ST_PIXEL;
				if (fin) begin
					chroma_left = (width_px * height_px) / 2;
					row_at = 0;
					col_at = 0;
					match_pos = 0;
					phase = (chroma_left == 0) ? PH_TOKEN : PH_CHROMA;
				end else if (col_at + 1 >= width_px) begin
					col_at = 0;
					row_at++;
				end else begin
					col_at++;
				end
			end
			PH_CHROMA: begin
				if (chroma_left > 0)
					chroma_left--;
				if (chroma_left == 0) begin
					match_pos = 0;
					phase = PH_TOKEN;
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic report(input string what, input int unsigned got_v,
		input int unsigned want_v);
		$display("mismatch on result %0d: %s got %0d want %0d", result_idx, what,
			got_v, want_v);
		miss_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		luma_item_t want;
		luma_item_t seen;
		luma_item_t next_item;
		bit         made;
		if (!arst_n) begin
			clear_parser();
			luma_q.delete();
			result_idx = 0;
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.pixel = m_axis_tdata[7:0];
				seen.row = m_axis_tdata[19:8];
				seen.column = m_axis_tdata[31:20];
				seen.last = m_axis_tlast;
				seen.status = m_axis_tuser;
				if (luma_q.size() == 0) begin
					report("item with nothing pending, status", seen.status, 0);
				end else begin
					want = luma_q.pop_front();
					if (seen.status !== want.status)
						report("status", seen.status, want.status);
					if (seen.pixel !== want.pixel)
						report("pixel", seen.pixel, want.pixel);
					if (seen.row !== want.row)
						report("row", seen.row, want.row);
					if (seen.column !== want.column)
						report("column", seen.column, want.column);
					if (seen.last !== want.last)
						report("frame_last", seen.last, want.last);
				end
				result_idx++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				step_parser(s_axis_tdata, s_axis_tuser, made, next_item);
				if (made)
					luma_q.insert(luma_q.size(), next_item);
			end
			outstanding <= luma_q.size();
		end
	end

endmodule

>>> sim/y4m_luma_extractor_unit_test.sv
`timescale 1ns / 1ps
// Luma extractor testbench top: byte stream stimulus, flow control and verdict.
module y4m_luma_extractor_unit_test
	import y4mle_pkg::*;
();

	localparam int unsigned WIDE_LUMA = 300;

	typedef struct packed {
		logic [7:0] data;
		logic       restart;
	} stream_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_valid = 1'b0;
	logic [7:0]  s_data = 8'h00;
	logic        s_user = 1'b0;
	logic        m_ready = 1'b0;
	wire         s_ready;
	wire         m_valid;
	wire  [31:0] m_data;
	wire  [1:0]  m_user;
	wire         m_last;
	int          fail_count;
	int          pending;

	stream_byte_t byte_q[$];
	bit           restart_next = 1'b0;
	bit           counting = 1'b1;
	bit           steady_tx = 1'b0;
	int unsigned  counted = 0;

	always #10 clk = ~clk;

	y4m_luma_extractor_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tuser  (s_user),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_user),
		.m_axis_tlast  (m_last)
	);

	y4m_luma_extractor_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tuser  (s_user),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_user),
		.m_axis_tlast  (m_last),
		.mismatches    (fail_count),
		.outstanding   (pending)
	);

	task automatic put(input logic [7:0] b);
		stream_byte_t it;
		it.data = b;
		it.restart = restart_next;
		byte_q.insert(byte_q.size(), it);
		restart_next = 1'b0;
		if (counting)
			counted++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	task automatic put_number(input int unsigned n);
		put_text($sformatf("%0d", n));
	endtask

	function automatic logic [7:0] pick_sep(input bit with_nl);
		logic [7:0] c;
		case ($urandom_range(7))
			0:       c = CH_TAB;
			1:       c = 8'h0B;
			2:       c = 8'h0C;
			3:       c = CH_CR;
			4:       c = with_nl ? CH_NEWLINE : CH_SPACE;
			default: c = CH_SPACE;
		endcase
		return c;
	endfunction

	function automatic string extra_tag();
		string t;
		case ($urandom_range(5))
			0:       t = "C420jpeg";
			1:       t = "Ip";
			2:       t = "F25:1";
			3:       t = "A0:0";
			4:       t = "XW99";
			default: t = "Cmono";
		endcase
		return t;
	endfunction

	task automatic put_junk(input int unsigned n);
		counting = 1'b0;
		repeat (n) put(8'($urandom_range(255)));
		counting = 1'b1;
	endtask

	task automatic gen_good_stream(input bit wide);
		int unsigned w_txt;
		int unsigned h_txt;
		int unsigned w_eff;
		int unsigned h_eff;
		int unsigned wpos;
		int unsigned hpos;
		int unsigned nframes;
		int unsigned nlead;
		bit          w_on;
		bit          w_bare;
		bit          h_bare;
		bit          dim_tag;
		w_txt = $urandom_range(1, 6);
		h_txt = $urandom_range(1, 6);
		w_on = 1'b1;
		w_bare = 1'b0;
		h_bare = 1'b0;
		case ($urandom_range(15))
			0: begin
				w_txt = $urandom_range(4097, 99999);
				h_txt = 0;
			end
			1: begin
				h_txt = $urandom_range(4097, 99999);
				w_txt = 0;
			end
			2: w_bare = 1'b1;
			3: h_bare = 1'b1;
			4: w_on = 1'b0;
			5: w_txt = 0;
			default: begin
			end
		endcase
		if (wide) begin
			w_on = 1'b1;
			w_bare = 1'b0;
			h_bare = 1'b0;
			w_txt = 99999;
			h_txt = 1;
		end
		w_eff = (!w_on || w_bare) ? 0 : ((w_txt > 4096) ? 4096 : w_txt);
		h_eff = h_bare ? 0 : ((h_txt > 4096) ? 4096 : h_txt);

		restart_next = 1'b1;
		nlead = ($urandom_range(2) == 0) ? $urandom_range(1, 2) : 0;
		repeat (nlead) put(pick_sep(1'b1));
		put_text("YUV4MPEG2");
		put(pick_sep(1'b1));
		wpos = $urandom_range(3);
		hpos = (wpos + $urandom_range(1, 3)) % 4;
		for (int slot = 0; slot < 4; slot++) begin
			dim_tag = 1'b0;
			if (slot == wpos && w_on) begin
				put(CH_W);
				if (!w_bare)
					put_number(w_txt);
				dim_tag = 1'b1;
			end else if (slot == hpos) begin
				put(CH_H);
				if (!h_bare)
					put_number(h_txt);
				dim_tag = 1'b1;
			end else if ($urandom_range(1) == 1) begin
				put_text(extra_tag());
			end
			repeat ($urandom_range(dim_tag ? 0 : 1, 2)) put(pick_sep(1'b0));
		end
		if ($urandom_range(3) == 0)
			put(CH_CR);
		put(CH_NEWLINE);

		nframes = wide ? 1 : $urandom_range(1, 3);
		repeat (nframes) begin
			nlead = ($urandom_range(2) == 0) ? $urandom_range(1, 2) : 0;
			repeat (nlead) put(pick_sep(1'b1));
			put_text("FRAME");
			put(pick_sep(1'b1));
			// saturated width: send the start of the frame only
			if (wide)
				repeat (WIDE_LUMA) put(8'($urandom_range(255)));
			else
				repeat (w_eff * h_eff + (w_eff * h_eff) / 2) put(8'($urandom_range(255)));
		end

		case ($urandom_range(3))
			1: put_text($urandom_range(1) ? "END" : "X");
			2: begin
				put_text("FRAME");
				put(8'($urandom_range(33, 126)));
			end
			3: put_text("FRAQ");
			default: begin
			end
		endcase
		put_junk($urandom_range(3));
	endtask

	task automatic gen_broken_stream();
		string       magic_txt;
		int unsigned k;
		magic_txt = "YUV4MPEG2";
		restart_next = 1'b1;
		if ($urandom_range(1) == 1) begin
			k = $urandom_range(8);
			for (int i = 0; i < k; i++)
				put(magic_txt[i]);
			put(8'($urandom_range(255)));
		end else begin
			put_text(magic_txt);
			put(8'($urandom_range(33, 255)));
		end
		put_junk($urandom_range(4));
	endtask

	task automatic gen_noise();
		counting = 1'b0;
		repeat ($urandom_range(3, 12)) begin
			restart_next = ($urandom_range(9) == 0);
			put(8'($urandom_range(255)));
		end
		counting = 1'b1;
	endtask

	task automatic send_byte(input stream_byte_t it);
		while (!steady_tx && $urandom_range(99) < 31) begin
			s_valid <= 1'b0;
			@(posedge clk);
		end
		s_valid <= 1'b1;
		s_data <= it.data;
		s_user <= it.restart;
		@(posedge clk);
		while (!s_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		s_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin : tx_side
		int unsigned directed_len;
		int unsigned sel;
		bit          wide_done;
		wide_done = 1'b0;

		// 1x1 frame with no chroma, then a non-space after FRAME
		restart_next = 1'b1;
		put_text("YUV4MPEG2 W1 H1");
		put(CH_NEWLINE);
		put_text("FRAME");
		put(CH_TAB);
		put(8'hFF);
		put_text("FRAME!");
		// leading space, magic word broken by a zero byte
		restart_next = 1'b1;
		put(CH_SPACE);
		put_text("YU");
		put(8'h00);
		directed_len = byte_q.size();

		while (counted < 1050) begin
			sel = $urandom_range(99);
			if (!wide_done && counted >= 500) begin
				gen_good_stream(1'b1);
				wide_done = 1'b1;
			end else if (sel < 72) begin
				gen_good_stream(1'b0);
			end else if (sel < 90) begin
				gen_broken_stream();
			end else begin
				gen_noise();
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < byte_q.size(); n++) begin
			if (n == directed_len || n == byte_q.size() / 2)
				drain();
			steady_tx = (n >= 300 && n < 550);
			send_byte(byte_q[n]);
		end
		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : rx_side
		int unsigned rx_cycle;
		rx_cycle = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle >= 600 && rx_cycle < 800)
				m_ready <= 1'b0;
			else if (rx_cycle >= 1000 && rx_cycle < 1500)
				m_ready <= 1'b1;
			else
				m_ready <= ($urandom_range(99) >= 31);
		end
	end

	initial begin : watchdog
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
